// File: hw/rtl/template_directive_tokenizer_macros.svh
// Assertion helpers for the template directive tokenizer.
// Each macro expects clk and rst_n in the scope where it is used.
`ifndef TEMPLATE_DIRECTIVE_TOKENIZER_MACROS_SVH
`define TEMPLATE_DIRECTIVE_TOKENIZER_MACROS_SVH

// Property that must hold at every edge outside reset
`define TDT_ASSERT_HOLDS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition that must hold in the cycle after a trigger
`define TDT_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: hw/rtl/tdt_pkg.sv
`default_nettype none

package tdt_pkg;

  // Request opcodes
  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_END  = 1'b1;

  // Result item kinds
  localparam logic [2:0] KIND_BYTE  = 3'd0;
  localparam logic [2:0] KIND_BEGIN = 3'd1;
  localparam logic [2:0] KIND_END   = 3'd2;
  localparam logic [2:0] KIND_DONE  = 3'd3;
  localparam logic [2:0] KIND_ERROR = 3'd4;

  // Segment types
  localparam logic [1:0] SEG_TEXT = 2'd0;
  localparam logic [1:0] SEG_CODE = 2'd1;
  localparam logic [1:0] SEG_EXPR = 2'd2;
  localparam logic [1:0] SEG_ESC  = 2'd3;

  // Characters of interest
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_DQ    = 8'h22;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_LT    = 8'h3C;
  localparam logic [7:0] CH_EQ    = 8'h3D;
  localparam logic [7:0] CH_GT    = 8'h3E;
  localparam logic [7:0] CH_QM    = 8'h3F;
  localparam logic [7:0] CH_BS    = 8'h5C;
  localparam logic [7:0] CH_C     = 8'h63;
  localparam logic [7:0] CH_H     = 8'h68;
  localparam logic [7:0] CH_N     = 8'h6E;
  localparam logic [7:0] CH_R     = 8'h72;
  localparam logic [7:0] CH_T     = 8'h74;
  localparam logic [7:0] CH_DEL   = 8'h7F;

  // Opener / closer matcher states
  typedef enum logic [2:0] {
    MS_TEXT = 3'd0,  // text, nothing held
    MS_LT   = 3'd1,  // holding "<"
    MS_LTQ  = 3'd2,  // holding "<?"
    MS_LTQH = 3'd3,  // holding "<?h"
    MS_OPEN = 3'd4,  // after "<?c", deciding on "="
    MS_DIR  = 3'd5,  // inside a directive
    MS_DIRQ = 3'd6   // inside a directive, holding "?"
  } tdt_match_t;

  // Work units of one request, emitted in index order
  localparam int NUM_UNITS = 12;
  localparam logic [3:0] U_BEG_TEXT = 4'd0;
  localparam logic [3:0] U_HELD_LT  = 4'd1;
  localparam logic [3:0] U_HELD_QM  = 4'd2;
  localparam logic [3:0] U_HELD_H   = 4'd3;
  localparam logic [3:0] U_TEXT_B   = 4'd4;
  localparam logic [3:0] U_END_TEXT = 4'd5;
  localparam logic [3:0] U_BEG_SEG  = 4'd6;
  localparam logic [3:0] U_CODE_QM  = 4'd7;
  localparam logic [3:0] U_CODE_B   = 4'd8;
  localparam logic [3:0] U_END_SEG  = 4'd9;
  localparam logic [3:0] U_DONE     = 4'd10;
  localparam logic [3:0] U_ERROR    = 4'd11;

  // Queue between front and back
  localparam int QUEUE_DEPTH = 4;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Classified request handed from front to back
  typedef struct packed {
    logic [NUM_UNITS-1:0] units;
    logic [7:0]           data;
    logic [1:0]           seg;
    logic [31:0]          line;
    logic [31:0]          err_line;
  } tdt_rec_t;

  // One result item
  typedef struct packed {
    logic [2:0]  kind;
    logic [1:0]  seg;
    logic [7:0]  data;
    logic [31:0] line;
    logic        last;
  } tdt_item_t;

  // Index of the last character of a text byte's escape (0, 1 or 3)
  function automatic logic [1:0] esc_last(input logic [7:0] b);
    logic [1:0] n;
    n = 2'd0;
    if (b == CH_DQ || b == CH_BS || b == CH_LF || b == CH_CR || b == CH_TAB) begin
      n = 2'd1;
    end else if (b < CH_SPACE || b == CH_DEL) begin
      n = 2'd3;
    end
    return n;
  endfunction

  // Character idx of a text byte's escaped form
  function automatic logic [7:0] esc_char(input logic [7:0] b, input logic [1:0] idx);
    logic [7:0] c;
    logic [1:0] n;
    n = esc_last(b);
    c = b;
    unique case (idx)
      2'd0: c = (n == 2'd0) ? b : CH_BS;
      2'd1: begin
        priority if (b == CH_LF) c = CH_N;
        else if (b == CH_CR)     c = CH_R;
        else if (b == CH_TAB)    c = CH_T;
        else if (n == 2'd1)      c = b;
        else                     c = CH_ZERO + {6'd0, b[7:6]};
      end
      2'd2: c = CH_ZERO + {5'd0, b[5:3]};
      default: c = CH_ZERO + {5'd0, b[2:0]};
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

// File: hw/rtl/tdt_if.sv
`default_nettype none

// Template byte request channel
interface tdt_in_if;
  logic       valid;
  logic       ready;
  logic       op;
  logic [7:0] in_byte;

  modport source (output valid, output op, output in_byte, input ready);
  modport sink   (input valid, input op, input in_byte, output ready);
endinterface

// Result item channel
interface tdt_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  item_kind;
  logic [1:0]  segment_type;
  logic [7:0]  out_byte;
  logic [31:0] line_number;
  logic        last;

  modport source (output valid, output item_kind, output segment_type, output out_byte,
                  output line_number, output last, input ready);
  modport sink   (input valid, input item_kind, input segment_type, input out_byte,
                  input line_number, input last, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/tdt_front.sv
`default_nettype none

module tdt_front
  import tdt_pkg::*;
#(
  parameter int LINE_COUNT_WIDTH
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  tdt_in_if.sink      in_if,
  input  wire logic   q_full,
  output logic        push,
  output tdt_rec_t    push_rec
);

  localparam logic [LINE_COUNT_WIDTH-1:0] LINE_TOP = '1;
  localparam logic [LINE_COUNT_WIDTH-1:0] LINE_ONE = LINE_COUNT_WIDTH'(1);

  tdt_match_t                  ms_r, ms_nxt;
  logic                        text_open_r, text_open_nxt;
  logic [1:0]                  cur_seg_r, cur_seg_nxt;
  logic [LINE_COUNT_WIDTH-1:0] line_r, line_nxt;
  logic [LINE_COUNT_WIDTH-1:0] opener_r, opener_nxt;

  logic                        accept;
  logic [7:0]                  b;
  logic [1:0]                  held_n;
  logic [LINE_COUNT_WIDTH-1:0] line_upd;
  logic [63:0]                 line_wide;
  logic [63:0]                 opener_wide;
  tdt_rec_t                    rec;

  assign in_if.ready = !q_full;
  assign accept      = in_if.valid && in_if.ready;
  assign b           = in_if.in_byte;

  // Classify the request into work units and next matcher state
  always_comb begin
    ms_nxt        = ms_r;
    text_open_nxt = text_open_r;
    cur_seg_nxt   = cur_seg_r;
    opener_nxt    = opener_r;
    held_n        = 2'd0;
    rec           = '0;
    rec.data      = b;
    rec.seg       = cur_seg_r;

    line_upd = line_r;
    if (in_if.op == OP_BYTE && b == CH_LF && line_r != LINE_TOP) begin
      line_upd = line_r + LINE_ONE;
    end
    line_nxt = line_upd;

    if (in_if.op == OP_END) begin
      if (ms_r <= MS_LTQH) begin
        held_n                 = ms_r[1:0];
        rec.units[U_END_TEXT]  = text_open_r;
        rec.units[U_DONE]      = 1'b1;
      end else begin
        rec.units[U_CODE_QM]   = (ms_r == MS_DIRQ);
        rec.units[U_ERROR]     = 1'b1;
      end
      ms_nxt        = MS_TEXT;
      text_open_nxt = 1'b0;
      cur_seg_nxt   = SEG_TEXT;
      line_nxt      = LINE_ONE;
      opener_nxt    = LINE_ONE;
    end else begin
      // open a text segment if none is open
      if (ms_r <= MS_LTQH && !text_open_r) begin
        rec.units[U_BEG_TEXT] = 1'b1;
        text_open_nxt         = 1'b1;
        cur_seg_nxt           = SEG_TEXT;
      end
      unique case (ms_r)
        MS_TEXT: begin
          if (b == CH_LT) ms_nxt = MS_LT;
          else rec.units[U_TEXT_B] = 1'b1;
        end
        MS_LT: begin
          if (b == CH_QM) begin
            ms_nxt = MS_LTQ;
          end else if (b == CH_LT) begin
            rec.units[U_TEXT_B] = 1'b1;
          end else begin
            held_n              = 2'd1;
            ms_nxt              = MS_TEXT;
            rec.units[U_TEXT_B] = 1'b1;
          end
        end
        MS_LTQ: begin
          if (b == CH_C) begin
            rec.units[U_END_TEXT] = 1'b1;
            text_open_nxt         = 1'b0;
            opener_nxt            = line_upd;
            ms_nxt                = MS_OPEN;
          end else if (b == CH_H) begin
            ms_nxt = MS_LTQH;
          end else if (b == CH_LT) begin
            held_n = 2'd2;
            ms_nxt = MS_LT;
          end else begin
            held_n              = 2'd2;
            ms_nxt              = MS_TEXT;
            rec.units[U_TEXT_B] = 1'b1;
          end
        end
        MS_LTQH: begin
          if (b == CH_EQ) begin
            rec.units[U_END_TEXT] = 1'b1;
            rec.units[U_BEG_SEG]  = 1'b1;
            rec.seg               = SEG_ESC;
            text_open_nxt         = 1'b0;
            opener_nxt            = line_upd;
            cur_seg_nxt           = SEG_ESC;
            ms_nxt                = MS_DIR;
          end else if (b == CH_LT) begin
            held_n = 2'd3;
            ms_nxt = MS_LT;
          end else begin
            held_n              = 2'd3;
            ms_nxt              = MS_TEXT;
            rec.units[U_TEXT_B] = 1'b1;
          end
        end
        MS_OPEN: begin
          rec.units[U_BEG_SEG] = 1'b1;
          if (b == CH_EQ) begin
            rec.seg     = SEG_EXPR;
            cur_seg_nxt = SEG_EXPR;
            ms_nxt      = MS_DIR;
          end else begin
            rec.seg     = SEG_CODE;
            cur_seg_nxt = SEG_CODE;
            if (b == CH_QM) begin
              ms_nxt = MS_DIRQ;
            end else begin
              ms_nxt              = MS_DIR;
              rec.units[U_CODE_B] = 1'b1;
            end
          end
        end
        MS_DIR: begin
          if (b == CH_QM) ms_nxt = MS_DIRQ;
          else rec.units[U_CODE_B] = 1'b1;
        end
        MS_DIRQ: begin
          if (b == CH_GT) begin
            rec.units[U_END_SEG] = 1'b1;
            ms_nxt               = MS_TEXT;
            text_open_nxt        = 1'b0;
            cur_seg_nxt          = SEG_TEXT;
          end else if (b == CH_QM) begin
            rec.units[U_CODE_QM] = 1'b1;
          end else begin
            rec.units[U_CODE_QM] = 1'b1;
            rec.units[U_CODE_B]  = 1'b1;
            ms_nxt               = MS_DIR;
          end
        end
        default: ms_nxt = MS_TEXT;
      endcase
    end

    // held opener prefix comes out as text
    rec.units[U_HELD_LT] = (held_n >= 2'd1);
    rec.units[U_HELD_QM] = (held_n >= 2'd2);
    rec.units[U_HELD_H]  = (held_n == 2'd3);

    // line numbers saturate to 32 bits on the way out
    line_wide    = 64'(line_upd);
    opener_wide  = 64'(opener_r);
    rec.line     = (line_wide > 64'h0000_0000_FFFF_FFFF) ? 32'hFFFF_FFFF : line_wide[31:0];
    rec.err_line = (opener_wide > 64'h0000_0000_FFFF_FFFF) ? 32'hFFFF_FFFF
                                                           : opener_wide[31:0];
  end

  assign push     = accept && (rec.units != '0);
  assign push_rec = rec;

  // Matcher state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ms_r        <= MS_TEXT;
      text_open_r <= 1'b0;
      cur_seg_r   <= SEG_TEXT;
      line_r      <= LINE_ONE;
      opener_r    <= LINE_ONE;
    end else if (accept) begin
      ms_r        <= ms_nxt;
      text_open_r <= text_open_nxt;
      cur_seg_r   <= cur_seg_nxt;
      line_r      <= line_nxt;
      opener_r    <= opener_nxt;
    end
  end

endmodule

`default_nettype wire

// File: hw/rtl/tdt_queue.sv
`default_nettype none

module tdt_queue
  import tdt_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     push,
  input  wire tdt_rec_t push_rec,
  output logic          full,
  input  wire logic     pop,
  output logic          empty,
  output tdt_rec_t      head_rec
);

  tdt_rec_t              entry_r [QUEUE_DEPTH];
  logic [QPTR_W-1:0]     wr_ptr_r, rd_ptr_r;
  logic [QCNT_W-1:0]     count_r, count_nxt;

  assign full      = (count_r == QCNT_W'(QUEUE_DEPTH));
  assign empty     = (count_r == '0);
  assign head_rec  = entry_r[rd_ptr_r];
  assign count_nxt = count_r + QCNT_W'(push) - QCNT_W'(pop);

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) wr_ptr_r <= wr_ptr_r + QPTR_W'(1);
      if (pop)  rd_ptr_r <= rd_ptr_r + QPTR_W'(1);
      count_r <= count_nxt;
    end
  end

  // Entry storage
  always_ff @(posedge clk) begin
    if (push) entry_r[wr_ptr_r] <= push_rec;
  end

endmodule

`default_nettype wire

// File: hw/rtl/tdt_back.sv
`default_nettype none

module tdt_back
  import tdt_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     q_empty,
  input  wire tdt_rec_t head_rec,
  output logic          q_pop,
  tdt_out_if.source     out_if
);

  logic        wv_r, wv_nxt;
  tdt_rec_t    rec_r, rec_nxt;
  logic [1:0]  sub_r, sub_nxt;
  logic        out_valid_r, out_valid_nxt;
  tdt_item_t   out_item_r;

  logic [3:0]           unit_idx;
  logic [NUM_UNITS-1:0] units_left;
  logic                 unit_done;
  logic                 emit;
  logic                 finish;
  tdt_item_t            item;

  // Pick the lowest pending unit
  always_comb begin
    unit_idx = 4'd0;
    for (int i = NUM_UNITS - 1; i >= 0; i--) begin
      if (rec_r.units[i]) unit_idx = 4'(i);
    end
  end

  // Build the result item for that unit
  always_comb begin
    item      = '0;
    item.line = rec_r.line;
    unique case (unit_idx)
      U_BEG_TEXT: item.kind = KIND_BEGIN;
      U_HELD_LT:  item.data = CH_LT;
      U_HELD_QM:  item.data = CH_QM;
      U_HELD_H:   item.data = CH_H;
      U_TEXT_B:   item.data = esc_char(rec_r.data, sub_r);
      U_END_TEXT: item.kind = KIND_END;
      U_BEG_SEG: begin
        item.kind = KIND_BEGIN;
        item.seg  = rec_r.seg;
      end
      U_CODE_QM: begin
        item.seg  = rec_r.seg;
        item.data = CH_QM;
      end
      U_CODE_B: begin
        item.seg  = rec_r.seg;
        item.data = rec_r.data;
      end
      U_END_SEG: begin
        item.kind = KIND_END;
        item.seg  = rec_r.seg;
      end
      U_DONE: item.kind = KIND_DONE;
      U_ERROR: begin
        item.kind = KIND_ERROR;
        item.line = rec_r.err_line;
      end
      default: item.kind = KIND_BYTE;
    endcase

    unit_done  = (unit_idx != U_TEXT_B) || (sub_r == esc_last(rec_r.data));
    units_left = rec_r.units;
    if (unit_done) units_left[unit_idx] = 1'b0;
    item.last  = unit_done && (units_left == '0);
  end

  assign emit   = wv_r && (!out_valid_r || out_if.ready);
  assign finish = emit && item.last;
  assign q_pop  = !q_empty && (!wv_r || finish);

  // Work register next state
  always_comb begin
    rec_nxt = rec_r;
    sub_nxt = sub_r;
    wv_nxt  = wv_r;
    if (emit) begin
      rec_nxt.units = units_left;
      sub_nxt       = unit_done ? 2'd0 : sub_r + 2'd1;
      if (item.last) wv_nxt = 1'b0;
    end
    if (q_pop) begin
      rec_nxt = head_rec;
      sub_nxt = 2'd0;
      wv_nxt  = 1'b1;
    end
    out_valid_nxt = emit ? 1'b1 : (out_if.ready ? 1'b0 : out_valid_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wv_r        <= 1'b0;
      sub_r       <= 2'd0;
      out_valid_r <= 1'b0;
    end else begin
      wv_r        <= wv_nxt;
      sub_r       <= sub_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    rec_r <= rec_nxt;
    if (emit) out_item_r <= item;
  end

  assign out_if.valid        = out_valid_r;
  assign out_if.item_kind    = out_item_r.kind;
  assign out_if.segment_type = out_item_r.seg;
  assign out_if.out_byte     = out_item_r.data;
  assign out_if.line_number  = out_item_r.line;
  assign out_if.last         = out_item_r.last;

endmodule

`default_nettype wire

// File: hw/rtl/template_directive_tokenizer.sv
// Template directive tokenizer.
// in_if takes one request per cycle: a template byte (op 0) or end of
// template (op 1). out_if gives result items: byte, segment begin, segment
// end, finished or unterminated error, each with its segment type and line,
// and last set on the final item of each request. A request may give no
// item at all (held opener prefix) or up to seven.
// Each request passes the queue, the expander's work register and the output
// register before its first item is on out_if. Throughput: one result item
// per cycle from the expander while out_if takes them; one-item requests
// stream at one per cycle. A four-entry queue between the classifier and the
// expander absorbs escape bursts; in_if.ready drops only when it is full.
// Reset: synchronous, active low; returns to text mode, line counter 1,
// queue empty, no result pending.
// Receiver stall: the output register holds its item until taken, the
// expander waits, the queue fills and then in_if.ready falls.
`default_nettype none

module template_directive_tokenizer
  import tdt_pkg::*;
#(
  parameter int LINE_COUNT_WIDTH = 32
) (
  input  wire logic   clk,
  input  wire logic   rst_n,
  tdt_in_if.sink      in_if,
  tdt_out_if.source   out_if
);

  logic     push, q_full, q_pop, q_empty;
  tdt_rec_t push_rec, head_rec;

  // Classifier: matcher state and line counting
  tdt_front #(
    .LINE_COUNT_WIDTH (LINE_COUNT_WIDTH)
  ) u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_if    (in_if),
    .q_full   (q_full),
    .push     (push),
    .push_rec (push_rec)
  );

  // Request queue
  tdt_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_rec (push_rec),
    .full     (q_full),
    .pop      (q_pop),
    .empty    (q_empty),
    .head_rec (head_rec)
  );

  // Expander and output register
  tdt_back u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_empty  (q_empty),
    .head_rec (head_rec),
    .q_pop    (q_pop),
    .out_if   (out_if)
  );

endmodule

`default_nettype wire

// File: hw/rtl/tdt_checker.sv
`default_nettype none

`include "template_directive_tokenizer_macros.svh"

module tdt_checker
  import tdt_pkg::*;
(
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [2:0]  item_kind,
  input wire logic [1:0]  segment_type,
  input wire logic [7:0]  out_byte,
  input wire logic [31:0] line_number,
  input wire logic        last
);

  logic [45:0] payload;
  assign payload = {item_kind, segment_type, out_byte, line_number, last};

  // Stalled item holds
  `TDT_ASSERT_NEXT(a_stall_hold, out_valid && !out_ready, out_valid && $stable(payload), "result changed while stalled")

  // Kind code in range
  `TDT_ASSERT_HOLDS(a_kind_range, out_valid |-> item_kind <= KIND_ERROR, "bad item kind")

  // Finished and error items close the request and carry no segment type
  `TDT_ASSERT_HOLDS(a_end_last, (out_valid && (item_kind == KIND_DONE || item_kind == KIND_ERROR)) |-> (last && segment_type == SEG_TEXT), "end item not last")

  // Escaped text never carries control bytes
  `TDT_ASSERT_HOLDS(a_text_print, (out_valid && item_kind == KIND_BYTE && segment_type == SEG_TEXT) |-> (out_byte >= CH_SPACE && out_byte != CH_DEL), "unescaped text byte")

endmodule

bind template_directive_tokenizer tdt_checker u_tdt_checker (
  .clk          (clk),
  .rst_n        (rst_n),
  .out_valid    (out_if.valid),
  .out_ready    (out_if.ready),
  .item_kind    (out_if.item_kind),
  .segment_type (out_if.segment_type),
  .out_byte     (out_if.out_byte),
  .line_number  (out_if.line_number),
  .last         (out_if.last)
);

`default_nettype wire

// File: tb/tdt_token_checker.sv
`default_nettype none

module tdt_token_checker
  import tdt_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  tdt_in_if         in_mon,
  tdt_out_if        out_mon,
  output int        fail_count,
  output int        outstanding
);

  localparam logic [31:0] LINE_MAX    = '1;
  localparam int          MAX_REPORTS = 200;

  // Mirror of the tokenizer state
  tdt_match_t  mstate;
  logic        text_open;
  logic [1:0]  cur_seg;
  logic [31:0] line_cnt;
  logic [31:0] opener_line;

  // Tokens predicted but not yet seen on the result channel
  tdt_item_t   pending_tokens[$];
  int          reported;

  function automatic void clear_state();
    mstate      = MS_TEXT;
    text_open   = 1'b0;
    cur_seg     = SEG_TEXT;
    line_cnt    = 32'd1;
    opener_line = 32'd1;
  endfunction

  function automatic void emit(input logic [2:0] kind, input logic [1:0] seg,
                               input logic [7:0] data, input logic [31:0] line);
    tdt_item_t t;
    t.kind = kind;
    t.seg  = seg;
    t.data = data;
    t.line = line;
    t.last = 1'b0;
    pending_tokens.push_back(t);
  endfunction

  // C string literal escaping of one text byte
  function automatic void emit_text(input logic [7:0] b);
    case (b)
      CH_DQ, CH_BS: begin
        emit(KIND_BYTE, SEG_TEXT, CH_BS, line_cnt);
        emit(KIND_BYTE, SEG_TEXT, b, line_cnt);
      end
      CH_LF: begin
        emit(KIND_BYTE, SEG_TEXT, CH_BS, line_cnt);
        emit(KIND_BYTE, SEG_TEXT, CH_N, line_cnt);
      end
      CH_CR: begin
        emit(KIND_BYTE, SEG_TEXT, CH_BS, line_cnt);
        emit(KIND_BYTE, SEG_TEXT, CH_R, line_cnt);
      end
      CH_TAB: begin
        emit(KIND_BYTE, SEG_TEXT, CH_BS, line_cnt);
        emit(KIND_BYTE, SEG_TEXT, CH_T, line_cnt);
      end
      default: begin
        if (b < CH_SPACE || b == CH_DEL) begin
          // backslash and three octal digits
          emit(KIND_BYTE, SEG_TEXT, CH_BS, line_cnt);
          emit(KIND_BYTE, SEG_TEXT, CH_ZERO + {6'd0, b[7:6]}, line_cnt);
          emit(KIND_BYTE, SEG_TEXT, CH_ZERO + {5'd0, b[5:3]}, line_cnt);
          emit(KIND_BYTE, SEG_TEXT, CH_ZERO + {5'd0, b[2:0]}, line_cnt);
        end else begin
          emit(KIND_BYTE, SEG_TEXT, b, line_cnt);
        end
      end
    endcase
  endfunction

  // A failed opener prefix comes out as text
  function automatic void flush_held();
    if (mstate >= MS_LT) emit_text(CH_LT);
    if (mstate >= MS_LTQ) emit_text(CH_QM);
    if (mstate >= MS_LTQH) emit_text(CH_H);
    mstate = MS_TEXT;
  endfunction

  function automatic void close_text();
    emit(KIND_END, SEG_TEXT, 8'h00, line_cnt);
    text_open   = 1'b0;
    opener_line = line_cnt;
  endfunction

  function automatic void code_byte(input logic [7:0] b);
    if (b == CH_QM) mstate = MS_DIRQ;
    else emit(KIND_BYTE, cur_seg, b, line_cnt);
  endfunction

  // Expected tokens for one accepted request
  function automatic void tokenize_step(input logic op, input logic [7:0] b);
    int        first;
    tdt_item_t t;
    first = pending_tokens.size();
    if (op == OP_END) begin
      if (mstate <= MS_LTQH) begin
        flush_held();
        if (text_open) emit(KIND_END, SEG_TEXT, 8'h00, line_cnt);
        emit(KIND_DONE, SEG_TEXT, 8'h00, line_cnt);
      end else begin
        // unterminated directive: error replaces end and finished
        if (mstate == MS_DIRQ) emit(KIND_BYTE, cur_seg, CH_QM, line_cnt);
        emit(KIND_ERROR, SEG_TEXT, 8'h00, opener_line);
      end
      clear_state();
    end else begin
      if (b == CH_LF && line_cnt != LINE_MAX) line_cnt = line_cnt + 32'd1;
      if (mstate <= MS_LTQH && !text_open) begin
        emit(KIND_BEGIN, SEG_TEXT, 8'h00, line_cnt);
        text_open = 1'b1;
        cur_seg   = SEG_TEXT;
      end
      case (mstate)
        MS_TEXT: begin
          if (b == CH_LT) mstate = MS_LT;
          else emit_text(b);
        end
        MS_LT: begin
          if (b == CH_QM) mstate = MS_LTQ;
          else if (b == CH_LT) emit_text(CH_LT);
          else begin
            flush_held();
            emit_text(b);
          end
        end
        MS_LTQ: begin
          if (b == CH_C) begin
            close_text();
            mstate = MS_OPEN;
          end else if (b == CH_H) begin
            mstate = MS_LTQH;
          end else if (b == CH_LT) begin
            flush_held();
            mstate = MS_LT;
          end else begin
            flush_held();
            emit_text(b);
          end
        end
        MS_LTQH: begin
          if (b == CH_EQ) begin
            close_text();
            cur_seg = SEG_ESC;
            emit(KIND_BEGIN, SEG_ESC, 8'h00, line_cnt);
            mstate = MS_DIR;
          end else if (b == CH_LT) begin
            flush_held();
            mstate = MS_LT;
          end else begin
            flush_held();
            emit_text(b);
          end
        end
        MS_OPEN: begin
          // "=" after "<?c" selects an output expression
          mstate = MS_DIR;
          if (b == CH_EQ) begin
            cur_seg = SEG_EXPR;
            emit(KIND_BEGIN, SEG_EXPR, 8'h00, line_cnt);
          end else begin
            cur_seg = SEG_CODE;
            emit(KIND_BEGIN, SEG_CODE, 8'h00, line_cnt);
            code_byte(b);
          end
        end
        MS_DIR: code_byte(b);
        MS_DIRQ: begin
          if (b == CH_GT) begin
            emit(KIND_END, cur_seg, 8'h00, line_cnt);
            mstate    = MS_TEXT;
            text_open = 1'b0;
            cur_seg   = SEG_TEXT;
          end else if (b == CH_QM) begin
            emit(KIND_BYTE, cur_seg, CH_QM, line_cnt);
          end else begin
            emit(KIND_BYTE, cur_seg, CH_QM, line_cnt);
            emit(KIND_BYTE, cur_seg, b, line_cnt);
            mstate = MS_DIR;
          end
        end
        default: ;
      endcase
    end
    // flag the final token of this request
    if (pending_tokens.size() > first) begin
      t      = pending_tokens.pop_back();
      t.last = 1'b1;
      pending_tokens.push_back(t);
    end
  endfunction

  // Compare one observed token with the oldest prediction
  function automatic void check_token();
    tdt_item_t want;
    tdt_item_t got;
    got.kind = out_mon.item_kind;
    got.seg  = out_mon.segment_type;
    got.data = out_mon.out_byte;
    got.line = out_mon.line_number;
    got.last = out_mon.last;
    if (pending_tokens.size() == 0) begin
      fail_count++;
      if (reported < MAX_REPORTS)
        $display("%0t: unexpected token kind=%0d seg=%0d byte=%02h line=%0d last=%0b",
                 $time, got.kind, got.seg, got.data, got.line, got.last);
      reported++;
    end else begin
      want = pending_tokens.pop_front();
      if (got.kind !== want.kind || got.seg !== want.seg || got.data !== want.data ||
          got.line !== want.line || got.last !== want.last) begin
        fail_count++;
        if (reported < MAX_REPORTS)
          $display("%0t: token mismatch: expected kind=%0d seg=%0d byte=%02h line=%0d last=%0b, %s",
                   $time, want.kind, want.seg, want.data, want.line, want.last,
                   $sformatf("actual kind=%0d seg=%0d byte=%02h line=%0d last=%0b",
                             got.kind, got.seg, got.data, got.line, got.last));
        reported++;
      end
    end
  endfunction

  initial begin
    fail_count = 0;
    reported   = 0;
    clear_state();
  end

  // Requests are predicted before tokens are checked; tokens trail by cycles
  always @(posedge clk) begin
    if (!rst_n) begin
      clear_state();
      pending_tokens.delete();
    end else begin
      if (in_mon.valid && in_mon.ready) tokenize_step(in_mon.op, in_mon.in_byte);
      if (out_mon.valid && out_mon.ready) check_token();
    end
    outstanding <= pending_tokens.size();
  end

endmodule

`default_nettype wire

// File: tb/testbench.sv
`default_nettype none

module testbench;
  import tdt_pkg::*;

  localparam int IDLE_LIMIT = 2000;
  localparam int LONG_HOLD  = 100;
  localparam int RAND_ITEMS = 210;
  localparam int FLOOD_LEN  = 40;

  typedef struct packed {
    logic       op;
    logic [7:0] data;
  } template_req_t;

  logic clk = 1'b0;
  logic rst_n;
  int   fail_count;
  int   tokens_due;
  int   idle_cycles = 0;
  bit   hold_req = 1'b0;

  template_req_t template_reqs[$];

  tdt_in_if  in_if ();
  tdt_out_if out_if ();

  template_directive_tokenizer DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_if),
    .out_if (out_if)
  );

  tdt_token_checker token_chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_mon      (in_if),
    .out_mon     (out_if),
    .fail_count  (fail_count),
    .outstanding (tokens_due)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Stimulus building
  task automatic add_req(input logic op, input logic [7:0] b);
    template_req_t r;
    r.op   = op;
    r.data = b;
    template_reqs.push_back(r);
  endtask

  // Byte biased toward the characters the matcher cares about
  function automatic logic [7:0] rand_char();
    logic [7:0] c;
    case ($urandom_range(0, 11))
      0, 1: c = CH_LT;
      2: c = CH_QM;
      3: c = CH_GT;
      4: c = CH_EQ;
      5: c = $urandom_range(0, 1) ? CH_C : CH_H;
      6: c = CH_LF;
      7: c = ($urandom_range(0, 3) == 0) ? CH_DEL : 8'($urandom_range(0, 31));
      8, 9: c = 8'($urandom_range(0, 255));
      default: c = 8'($urandom_range(32, 126));
    endcase
    return c;
  endfunction

  task automatic add_body();
    repeat ($urandom_range(0, 5)) add_req(OP_BYTE, rand_char());
  endtask

  // One template: text runs, directives, broken openers, then end of template
  task automatic add_template();
    int k;
    repeat ($urandom_range(0, 5)) begin
      case ($urandom_range(0, 9))
        0, 1, 2: repeat ($urandom_range(1, 6)) add_req(OP_BYTE, rand_char());
        3, 4: begin
          add_req(OP_BYTE, CH_LT); add_req(OP_BYTE, CH_QM); add_req(OP_BYTE, CH_C);
          add_body();
          add_req(OP_BYTE, CH_QM); add_req(OP_BYTE, CH_GT);
        end
        5: begin
          add_req(OP_BYTE, CH_LT); add_req(OP_BYTE, CH_QM); add_req(OP_BYTE, CH_C);
          add_req(OP_BYTE, CH_EQ);
          add_body();
          add_req(OP_BYTE, CH_QM); add_req(OP_BYTE, CH_GT);
        end
        6: begin
          add_req(OP_BYTE, CH_LT); add_req(OP_BYTE, CH_QM); add_req(OP_BYTE, CH_H);
          add_req(OP_BYTE, CH_EQ);
          add_body();
          add_req(OP_BYTE, CH_QM); add_req(OP_BYTE, CH_GT);
        end
        7: begin
          // opener prefix followed by a random byte that may cut it short
          k = $urandom_range(1, 3);
          add_req(OP_BYTE, CH_LT);
          if (k >= 2) add_req(OP_BYTE, CH_QM);
          if (k >= 3) add_req(OP_BYTE, CH_H);
          add_req(OP_BYTE, rand_char());
        end
        default: repeat ($urandom_range(1, 4)) add_req(OP_BYTE, 8'($urandom_range(0, 255)));
      endcase
    end
    // sometimes leave a directive open at the end
    if ($urandom_range(0, 5) == 0) begin
      k = $urandom_range(0, 2);
      add_req(OP_BYTE, CH_LT); add_req(OP_BYTE, CH_QM);
      add_req(OP_BYTE, (k == 2) ? CH_H : CH_C);
      if (k != 0) begin
        add_req(OP_BYTE, CH_EQ);
        add_body();
        if ($urandom_range(0, 1)) add_req(OP_BYTE, CH_QM);
      end
    end
    add_req(OP_END, 8'($urandom_range(0, 255)));
  endtask

  task automatic drive_req(input template_req_t r);
    in_if.valid   <= 1'b1;
    in_if.op      <= r.op;
    in_if.in_byte <= r.data;
    do @(posedge clk); while (!in_if.ready);
  endtask

  // Result side pacing, with a long hold-off on request
  initial begin : sink_pacing
    int tick;
    tick = 0;
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_if.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
        hold_req = 1'b0;
      end
      case ((tick / 64) % 4)
        0: out_if.ready <= 1'b1;
        1: out_if.ready <= (tick % 4) != 0;
        2: out_if.ready <= $urandom_range(0, 1);
        default: out_if.ready <= ($urandom_range(0, 3) == 0);
      endcase
      tick++;
    end
  end

  // Watchdog on cycles with no handshake on either channel
  always @(posedge clk) begin
    if (!rst_n || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("template_directive_tokenizer test failed");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int n_directed;
    int flood_at;
    int idx;
    int burst_left;
    int gap;
    bit no_gap;
    rst_n         <= 1'b0;
    in_if.valid   <= 1'b0;
    in_if.op      <= OP_BYTE;
    in_if.in_byte <= 8'h00;

    // empty template
    add_req(OP_END, 8'h00);
    // byte extremes and text escapes
    add_req(OP_BYTE, 8'h00); add_req(OP_BYTE, 8'hFF); add_req(OP_BYTE, CH_DQ);
    add_req(OP_BYTE, CH_BS); add_req(OP_BYTE, CH_LF); add_req(OP_BYTE, CH_TAB);
    add_req(OP_BYTE, CH_DEL);
    // escaped output with a held "?" inside, then closed
    add_req(OP_BYTE, CH_LT); add_req(OP_BYTE, CH_QM); add_req(OP_BYTE, CH_H);
    add_req(OP_BYTE, CH_EQ); add_req(OP_BYTE, 8'h78); add_req(OP_BYTE, CH_QM);
    add_req(OP_BYTE, CH_GT);
    // end of template with "<?" still held
    add_req(OP_BYTE, CH_LT); add_req(OP_BYTE, CH_QM); add_req(OP_END, 8'hFF);
    // end right after "<?c", opener at the very start
    add_req(OP_BYTE, CH_LT); add_req(OP_BYTE, CH_QM); add_req(OP_BYTE, CH_C);
    add_req(OP_END, 8'h00);
    // doubled "<", output expression, end with "?" held
    add_req(OP_BYTE, CH_LT); add_req(OP_BYTE, CH_LT); add_req(OP_BYTE, CH_QM);
    add_req(OP_BYTE, CH_C); add_req(OP_BYTE, CH_EQ); add_req(OP_BYTE, CH_QM);
    add_req(OP_END, 8'h00);
    n_directed = template_reqs.size();

    while (template_reqs.size() < RAND_ITEMS) add_template();
    flood_at = n_directed + 60;

    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    idx        = 0;
    burst_left = $urandom_range(1, 20);
    while (idx < template_reqs.size()) begin
      if (idx == n_directed) begin
        // let every token of the directed part drain first
        in_if.valid <= 1'b0;
        @(posedge clk);
        while (tokens_due != 0) @(posedge clk);
      end
      if (idx == flood_at) hold_req = 1'b1;
      drive_req(template_reqs[idx]);
      idx++;
      no_gap = (idx >= flood_at && idx < flood_at + FLOOD_LEN);
      burst_left--;
      if (burst_left <= 0 && !no_gap) begin
        gap = $urandom_range(0, 8);
        if (gap > 0) begin
          in_if.valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
        burst_left = $urandom_range(1, 20);
      end
    end
    in_if.valid <= 1'b0;

    @(posedge clk);
    while (tokens_due != 0) @(posedge clk);
    repeat (10) @(posedge clk);
    if (fail_count == 0 && tokens_due == 0) begin
      $display("template_directive_tokenizer test passed");
    end else begin
      $display("template_directive_tokenizer test failed");
    end
    $finish;
  end

endmodule

`default_nettype wire
